// ===== design/ppi_pkg.sv =====
`default_nettype none
package ppi_pkg;

   // Result kinds carried on the response tuser.
   localparam logic [1:0] KIND_ACCEPT = 2'd0;
   localparam logic [1:0] KIND_DROP   = 2'd1;
   localparam logic [1:0] KIND_PART   = 2'd2;
   localparam logic [1:0] KIND_NONE   = 2'd3;

   // One pool entry as it sits in the memory.
   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [31:0] life;
   } entry_type;

   // Divide a Q32.32 product by 65536, rounding to nearest with ties upward.
   function automatic logic signed [47:0] round_q16(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = p + 64'sd32768;
      return t[63:16];
   endfunction

   // Clamp a wide signed value to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
      logic signed [31:0] r;
      if (v > 49'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -49'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== design/ppi_pool_mem.sv =====
`default_nettype none
module ppi_pool_mem #(
   parameter int DEPTH = 64,
   parameter int AW = 6
) (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [AW-1:0]       wr_addr,
   input  wire ppi_pkg::entry_type  wr_data,
   input  wire logic                rd_en,
   input  wire logic [AW-1:0]       rd_addr,
   output ppi_pkg::entry_type       rd_data
);

   ppi_pkg::entry_type mem [DEPTH];

   // Single write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== design/particle_pool_integrator.sv =====
`default_nettype none
// Particle pool of POOL_SIZE entries in Q16.16. A spawn request steps through
// accept, multiply, write and deliver; a tick request steps through memory
// read, multiply, and update and write back for each particle visited, then
// closes through an end and a final state. The pace is
// set by the single read port of the pool memory and the read-modify-write of
// each visited slot. One request is worked on at a time; the next is accepted
// once the last response of the current one sits in the output register.
// Survivors are emitted one step behind the walk so that the final one can
// carry tlast; a tick with no survivors gives a single response of kind none.
module particle_pool_integrator #(
   parameter int POOL_SIZE = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, spawn_life, time_step, zero fill
   input  wire logic [247:0] req_tdata,
   // func
   input  wire logic         req_tuser,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // slot, out_pos_x, out_pos_y, out_pos_z, out_life, zero fill
   output logic [135:0]      rsp_tdata,
   // kind
   output logic [1:0]        rsp_tuser,
   output logic              rsp_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic         csr_wr_en,
   input  wire logic [30:0]  csr_wr_data
);

   localparam int IDX_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
   localparam int CNT_W = $clog2(POOL_SIZE + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SMUL  = 3'd1;
   localparam logic [2:0] ST_SFIN  = 3'd2;
   localparam logic [2:0] ST_RD    = 3'd3;
   localparam logic [2:0] ST_TMUL  = 3'd4;
   localparam logic [2:0] ST_TFIN  = 3'd5;
   localparam logic [2:0] ST_END   = 3'd6;
   localparam logic [2:0] ST_FINAL = 3'd7;

   logic [2:0]       state_ff, state_in;
   logic [30:0]      speed_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] src_ff, src_in;

   // Latched request fields.
   logic signed [31:0] rq_pos_ff [3];
   logic signed [31:0] rq_dir_ff [3];
   logic [30:0]        rq_life_ff;
   logic [19:0]        rq_dt_ff;

   logic signed [63:0] prod_ff [3];
   logic signed [63:0] prod_in [3];

   // Held survivor and final response.
   logic               pend_vld_ff, pend_vld_in;
   logic [5:0]         pend_slot_ff;
   logic signed [31:0] pend_pos_ff [3];
   logic signed [31:0] pend_life_ff;
   logic [1:0]         fin_kind_ff;
   logic [5:0]         fin_slot_ff;
   logic signed [31:0] fin_pos_ff [3];
   logic signed [31:0] fin_life_ff;

   // Output register.
   logic               out_vld_ff;
   logic [1:0]         out_kind_ff;
   logic               out_last_ff;
   logic [5:0]         out_slot_ff;
   logic signed [31:0] out_pos_ff [3];
   logic signed [31:0] out_life_ff;

   ppi_pkg::entry_type rd_data;
   ppi_pkg::entry_type wr_data;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;

   logic signed [31:0] new_pos [3];
   logic signed [31:0] new_vel [3];
   logic signed [31:0] new_life;
   logic signed [31:0] mul_a [3];
   logic signed [32:0] mul_b;
   logic signed [64:0] mul_full [3];
   logic               alive;
   logic               out_free;
   logic               push_pend;
   logic               tfin_go;
   logic               req_acc;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !out_vld_ff || rsp_tready;

   // Shared multipliers: direction times speed on a spawn, velocity times dt on a tick.
   always_comb begin
      if (state_ff == ST_SMUL) begin
         mul_a[0] = rq_dir_ff[0];
         mul_a[1] = rq_dir_ff[1];
         mul_a[2] = rq_dir_ff[2];
         mul_b    = {2'b00, speed_ff};
      end else begin
         mul_a[0] = rd_data.vel_x;
         mul_a[1] = rd_data.vel_y;
         mul_a[2] = rd_data.vel_z;
         mul_b    = {13'b0, rq_dt_ff};
      end
      for (int k = 0; k < 3; k++) begin
         mul_full[k] = mul_a[k] * mul_b;
         prod_in[k]  = mul_full[k][63:0];
      end
   end

   // Rounded results for both request types.
   always_comb begin
      logic signed [47:0] step;
      logic signed [31:0] base [3];
      base[0] = rd_data.pos_x;
      base[1] = rd_data.pos_y;
      base[2] = rd_data.pos_z;
      for (int k = 0; k < 3; k++) begin
         step       = ppi_pkg::round_q16(prod_ff[k]);
         new_vel[k] = ppi_pkg::sat32({step[47], step});
         new_pos[k] = ppi_pkg::sat32({{17{base[k][31]}}, base[k]} + {step[47], step});
      end
      new_life = ppi_pkg::sat32({{17{rd_data.life[31]}}, rd_data.life} - {29'b0, rq_dt_ff});
   end

   assign alive     = (new_life > 32'sd0);
   assign tfin_go   = !alive || !pend_vld_ff || out_free;
   assign push_pend = (state_ff == ST_TFIN) && alive && pend_vld_ff && out_free;

   // Memory write: new spawn at the fill count, survivor to the slot being visited.
   always_comb begin
      wr_data = rd_data;
      if (state_ff == ST_SFIN) begin
         wr_en         = 1'b1;
         wr_addr       = count_ff[IDX_W-1:0];
         wr_data.pos_x = rq_pos_ff[0];
         wr_data.pos_y = rq_pos_ff[1];
         wr_data.pos_z = rq_pos_ff[2];
         wr_data.vel_x = new_vel[0];
         wr_data.vel_y = new_vel[1];
         wr_data.vel_z = new_vel[2];
         wr_data.life  = {1'b0, rq_life_ff};
      end else begin
         wr_en         = (state_ff == ST_TFIN) && alive && tfin_go;
         wr_addr       = i_ff[IDX_W-1:0];
         wr_data.pos_x = new_pos[0];
         wr_data.pos_y = new_pos[1];
         wr_data.pos_z = new_pos[2];
         wr_data.life  = new_life;
      end
   end

   ppi_pool_mem #(
      .DEPTH (POOL_SIZE),
      .AW    (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (state_ff == ST_RD),
      .rd_addr (src_ff),
      .rd_data (rd_data)
   );

   // Sequencer.
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      n_in        = n_ff;
      i_in        = i_ff;
      src_in      = src_ff;
      pend_vld_in = pend_vld_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (!req_tuser) begin
                  state_in = (count_ff >= CNT_W'(POOL_SIZE)) ? ST_FINAL : ST_SMUL;
               end else begin
                  n_in   = count_ff;
                  i_in   = '0;
                  src_in = '0;
                  state_in = (count_ff == '0) ? ST_END : ST_RD;
               end
            end
         end
         ST_SMUL: state_in = ST_SFIN;
         ST_SFIN: begin
            count_in = count_ff + 1'b1;
            state_in = ST_FINAL;
         end
         ST_RD:   state_in = ST_TMUL;
         ST_TMUL: state_in = ST_TFIN;
         ST_TFIN: begin
            if (tfin_go) begin
               if (alive) begin
                  pend_vld_in = 1'b1;
                  i_in        = i_ff + 1'b1;
                  src_in      = IDX_W'(i_ff + 1'b1);
                  state_in    = ((i_ff + 1'b1) < n_ff) ? ST_RD : ST_END;
               end else begin
                  // Last live particle moves into this slot and is processed here.
                  n_in     = n_ff - 1'b1;
                  src_in   = IDX_W'(n_ff - 1'b1);
                  state_in = (i_ff < (n_ff - 1'b1)) ? ST_RD : ST_END;
               end
            end
         end
         ST_END: begin
            count_in    = n_ff;
            pend_vld_in = 1'b0;
            state_in    = ST_FINAL;
         end
         ST_FINAL: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         speed_ff    <= 31'd65536;
         count_ff    <= '0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         pend_vld_ff <= pend_vld_in;
         if (csr_wr_en) begin
            speed_ff <= csr_wr_data;
         end
         if (push_pend || (state_ff == ST_FINAL && out_free)) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      i_ff   <= i_in;
      src_ff <= src_in;
      if (req_acc) begin
         rq_pos_ff[0] <= req_tdata[31:0];
         rq_pos_ff[1] <= req_tdata[63:32];
         rq_pos_ff[2] <= req_tdata[95:64];
         rq_dir_ff[0] <= req_tdata[127:96];
         rq_dir_ff[1] <= req_tdata[159:128];
         rq_dir_ff[2] <= req_tdata[191:160];
         rq_life_ff   <= req_tdata[222:192];
         rq_dt_ff     <= req_tdata[242:223];
      end
      if (state_ff == ST_SMUL || state_ff == ST_TMUL) begin
         for (int k = 0; k < 3; k++) begin
            prod_ff[k] <= prod_in[k];
         end
      end
      // Newest survivor replaces the held one.
      if (state_ff == ST_TFIN && alive && tfin_go) begin
         pend_slot_ff <= 6'(i_ff[IDX_W-1:0]);
         for (int k = 0; k < 3; k++) begin
            pend_pos_ff[k] <= new_pos[k];
         end
         pend_life_ff <= new_life;
      end
      // Final response of the current request.
      if (state_ff == ST_IDLE && req_acc && !req_tuser) begin
         fin_kind_ff <= ppi_pkg::KIND_DROP;
         fin_slot_ff <= '0;
         for (int k = 0; k < 3; k++) begin
            fin_pos_ff[k] <= '0;
         end
         fin_life_ff <= '0;
      end else if (state_ff == ST_SFIN) begin
         fin_kind_ff <= ppi_pkg::KIND_ACCEPT;
         fin_slot_ff <= 6'(count_ff[IDX_W-1:0]);
         for (int k = 0; k < 3; k++) begin
            fin_pos_ff[k] <= rq_pos_ff[k];
         end
         fin_life_ff <= {1'b0, rq_life_ff};
      end else if (state_ff == ST_END) begin
         if (pend_vld_ff) begin
            fin_kind_ff <= ppi_pkg::KIND_PART;
            fin_slot_ff <= pend_slot_ff;
            for (int k = 0; k < 3; k++) begin
               fin_pos_ff[k] <= pend_pos_ff[k];
            end
            fin_life_ff <= pend_life_ff;
         end else begin
            fin_kind_ff <= ppi_pkg::KIND_NONE;
            fin_slot_ff <= '0;
            for (int k = 0; k < 3; k++) begin
               fin_pos_ff[k] <= '0;
            end
            fin_life_ff <= '0;
         end
      end
      // Output register load.
      if (push_pend) begin
         out_kind_ff <= ppi_pkg::KIND_PART;
         out_last_ff <= 1'b0;
         out_slot_ff <= pend_slot_ff;
         for (int k = 0; k < 3; k++) begin
            out_pos_ff[k] <= pend_pos_ff[k];
         end
         out_life_ff <= pend_life_ff;
      end else if (state_ff == ST_FINAL && out_free) begin
         out_kind_ff <= fin_kind_ff;
         out_last_ff <= 1'b1;
         out_slot_ff <= fin_slot_ff;
         for (int k = 0; k < 3; k++) begin
            out_pos_ff[k] <= fin_pos_ff[k];
         end
         out_life_ff <= fin_life_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {2'b00, out_life_ff, out_pos_ff[2], out_pos_ff[1], out_pos_ff[0],
                        out_slot_ff};

endmodule
`default_nettype wire

// ===== design/ppi_checker.sv =====
`default_nettype none
module ppi_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic [135:0] rsp_tdata,
   input wire logic [1:0]   rsp_tuser,
   input wire logic         rsp_tlast,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready
);

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // One request at a time: busy right after an accept.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // Only particle responses may be non-final.
   a_kind_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ppi_pkg::KIND_PART |-> rsp_tlast)
      else $error("non-particle response without last");

   // While idle, any waiting response is the final one.
   a_idle_last: assert property (@(posedge clock) disable iff (reset)
      req_tready && rsp_tvalid |-> rsp_tlast)
      else $error("idle with a partial response pending");

   // Reset leaves no response.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind particle_pool_integrator ppi_checker u_ppi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
`default_nettype wire
